[sv/bis_pkg.sv]
package bis_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FRAC_BITS  = 16;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int POS_W = 12 + 24;
    localparam int INT_W = POS_W - FRAC_BITS;
    localparam int FQ_W = FRAC_BITS + 1;

    localparam logic [1:0] CFG_SRC_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_SRC_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_INV_SCALE_X = 2'd2;
    localparam logic [1:0] CFG_INV_SCALE_Y = 2'd3;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [11:0] coord_x;
        logic [11:0] coord_y;
        logic [7:0]  in_red;
        logic [7:0]  in_green;
        logic [7:0]  in_blue;
        logic [7:0]  in_alpha;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } out_item_t;

    // Classified command passed from the front to the back.
    typedef struct packed {
        logic                 is_load;
        logic [AW-1:0]        addr0;
        logic [AW-1:0]        addr1;
        logic [AW-1:0]        addr2;
        logic [AW-1:0]        addr3;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
        logic [31:0]          pixel;
    } cmd_t;

endpackage

[sv/bis_front.sv]
module bis_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  bis_pkg::in_item_t  in_item,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output bis_pkg::cmd_t      cmd
);
    localparam int XW = bis_pkg::XW;
    localparam int YW = bis_pkg::YW;
    localparam int IW = bis_pkg::INT_W;
    localparam int FB = bis_pkg::FRAC_BITS;

    logic [8:0]  src_width_reg, src_height_reg;
    logic [23:0] inv_x_reg, inv_y_reg;
    logic [XW:0] lim_x;
    logic [YW:0] lim_y;

    // Stage 1: multiply.
    logic        s1_valid_reg;
    logic        s1_load_reg;
    logic        s1_drop_reg;
    logic [bis_pkg::POS_W-1:0] s1_px_reg, s1_py_reg;
    logic [31:0] s1_pixel_reg;
    logic [XW-1:0] s1_lx_reg;
    logic [YW-1:0] s1_ly_reg;
    // Stage 2: output register.
    logic          s2_valid_reg;
    bis_pkg::cmd_t s2_cmd_reg;
    logic          s2_en, s1_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= 9'd256;
            src_height_reg <= 9'd256;
            inv_x_reg      <= 24'd65536;
            inv_y_reg      <= 24'd65536;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bis_pkg::CFG_SRC_WIDTH:   src_width_reg  <= cfg_data[8:0];
                bis_pkg::CFG_SRC_HEIGHT:  src_height_reg <= cfg_data[8:0];
                bis_pkg::CFG_INV_SCALE_X: inv_x_reg      <= cfg_data;
                bis_pkg::CFG_INV_SCALE_Y: inv_y_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        lim_x = (src_width_reg == 9'd0) ? (XW+1)'(1) :
                (src_width_reg > 9'(bis_pkg::MAX_WIDTH)) ? (XW+1)'(bis_pkg::MAX_WIDTH) :
                (XW+1)'(src_width_reg);
        lim_y = (src_height_reg == 9'd0) ? (YW+1)'(1) :
                (src_height_reg > 9'(bis_pkg::MAX_HEIGHT)) ? (YW+1)'(bis_pkg::MAX_HEIGHT) :
                (YW+1)'(src_height_reg);
    end

    assign s2_en = !s2_valid_reg || cmd_ready;
    assign s1_en = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_en) begin
            s1_valid_reg <= in_valid;
        end
        if (s1_en) begin
            s1_load_reg  <= (in_item.req_type == bis_pkg::REQ_LOAD);
            s1_drop_reg  <= (in_item.coord_x >= 12'(bis_pkg::MAX_WIDTH)) ||
                            (in_item.coord_y >= 12'(bis_pkg::MAX_HEIGHT));
            s1_px_reg    <= 36'(in_item.coord_x) * 36'(inv_x_reg);
            s1_py_reg    <= 36'(in_item.coord_y) * 36'(inv_y_reg);
            s1_pixel_reg <= {in_item.in_alpha, in_item.in_blue,
                             in_item.in_green, in_item.in_red};
            s1_lx_reg    <= in_item.coord_x[XW-1:0];
            s1_ly_reg    <= in_item.coord_y[YW-1:0];
        end
    end

    function automatic logic [XW-1:0] clamp_x(input logic [IW:0] v, input logic [XW:0] lim);
        clamp_x = (v >= (IW+1)'(lim)) ? XW'(lim - 1'b1) : v[XW-1:0];
    endfunction

    function automatic logic [YW-1:0] clamp_y(input logic [IW:0] v, input logic [YW:0] lim);
        clamp_y = (v >= (IW+1)'(lim)) ? YW'(lim - 1'b1) : v[YW-1:0];
    endfunction

    logic [IW:0]   ix, iy;
    logic [XW-1:0] x0, x1;
    logic [YW-1:0] y0, y1;
    bis_pkg::cmd_t c_next;

    always_comb begin
        ix = (IW+1)'(s1_px_reg[bis_pkg::POS_W-1:FB]);
        iy = (IW+1)'(s1_py_reg[bis_pkg::POS_W-1:FB]);
        x0 = clamp_x(ix, lim_x);
        x1 = clamp_x(ix + 1'b1, lim_x);
        y0 = clamp_y(iy, lim_y);
        y1 = clamp_y(iy + 1'b1, lim_y);
        c_next.is_load = s1_load_reg;
        c_next.fx    = s1_px_reg[FB-1:0];
        c_next.fy    = s1_py_reg[FB-1:0];
        c_next.pixel = s1_pixel_reg;
        if (s1_load_reg) begin
            c_next.addr0 = {s1_ly_reg, s1_lx_reg};
        end else begin
            c_next.addr0 = {y0, x0};
        end
        c_next.addr1 = {y0, x1};
        c_next.addr2 = {y1, x0};
        c_next.addr3 = {y1, x1};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_en) begin
            // Loads outside the store are dropped here.
            s2_valid_reg <= s1_valid_reg && !(s1_load_reg && s1_drop_reg);
        end
        if (s2_en) begin
            s2_cmd_reg <= c_next;
        end
    end

    assign cmd_valid = s2_valid_reg;
    assign cmd = s2_cmd_reg;

endmodule

[sv/bis_fifo.sv]
module bis_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  bis_pkg::cmd_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output bis_pkg::cmd_t rd_data
);
    bis_pkg::cmd_t mem_reg [4];
    logic [2:0] wptr_reg, rptr_reg;
    logic [2:0] count;
    logic do_wr, do_rd;

    assign count    = wptr_reg - rptr_reg;
    assign wr_ready = (count != 3'd4);
    assign rd_valid = (count != 3'd0);
    assign rd_data  = mem_reg[rptr_reg[1:0]];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 3'd0;
            rptr_reg <= 3'd0;
        end else begin
            if (do_wr) wptr_reg <= wptr_reg + 3'd1;
            if (do_rd) rptr_reg <= rptr_reg + 3'd1;
        end
        if (do_wr) mem_reg[wptr_reg[1:0]] <= wr_data;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= 3'd4) else $error("queue count out of range");
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (count == 3'd4) && !do_rd |=> count == 3'd4) else $error("full queue lost entry");
    a_empty_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (count == 3'd0) && !wr_valid |=> count == 3'd0) else $error("empty queue gained entry");

endmodule

[sv/bis_back.sv]
module bis_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  bis_pkg::cmd_t      cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output bis_pkg::out_item_t out_item
);
    localparam int FB = bis_pkg::FRAC_BITS;
    localparam int FQ = bis_pkg::FQ_W;
    localparam int HW = 8 + FQ;
    localparam int VW = HW + FQ;

    // Four banks keep the store single-ported per read: each holds the full image
    // so the four neighbors are read at once.
    logic [31:0] bank0 [1 << bis_pkg::AW];
    logic [31:0] bank1 [1 << bis_pkg::AW];
    logic [31:0] bank2 [1 << bis_pkg::AW];
    logic [31:0] bank3 [1 << bis_pkg::AW];

    logic advance;
    logic r_valid_reg, h_valid_reg, v_valid_reg;
    logic [31:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic [FB-1:0] r_fx_reg, r_fy_reg, h_fy_reg;
    logic [HW-1:0] top_reg [4];
    logic [HW-1:0] bot_reg [4];
    bis_pkg::out_item_t v_reg;
    logic smp;

    assign advance   = !v_valid_reg || out_ready;
    assign cmd_ready = advance;
    assign smp = cmd_valid && !cmd.is_load;

    always_ff @(posedge aclk) begin
        if (cmd_valid && cmd.is_load && advance) begin
            bank0[cmd.addr0] <= cmd.pixel;
            bank1[cmd.addr0] <= cmd.pixel;
            bank2[cmd.addr0] <= cmd.pixel;
            bank3[cmd.addr0] <= cmd.pixel;
        end
        if (advance) begin
            p0_reg <= bank0[cmd.addr0];
            p1_reg <= bank1[cmd.addr1];
            p2_reg <= bank2[cmd.addr2];
            p3_reg <= bank3[cmd.addr3];
            r_fx_reg <= cmd.fx;
            r_fy_reg <= cmd.fy;
        end
    end

    logic [FQ-1:0] wx0, wx1, wy0, wy1;
    logic [VW-1:0] vsum [4];
    assign wx1 = FQ'(r_fx_reg);
    assign wx0 = (FQ'(1) << FB) - wx1;
    assign wy1 = FQ'(h_fy_reg);
    assign wy0 = (FQ'(1) << FB) - wy1;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            vsum[c] = VW'(top_reg[c]) * VW'(wy0) + VW'(bot_reg[c]) * VW'(wy1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            v_valid_reg <= 1'b0;
        end else if (advance) begin
            r_valid_reg <= smp;
            h_valid_reg <= r_valid_reg;
            v_valid_reg <= h_valid_reg;
        end
        if (advance) begin
            h_fy_reg <= r_fy_reg;
            for (int c = 0; c < 4; c++) begin
                top_reg[c] <= HW'(p0_reg[c*8 +: 8]) * HW'(wx0) +
                              HW'(p1_reg[c*8 +: 8]) * HW'(wx1);
                bot_reg[c] <= HW'(p2_reg[c*8 +: 8]) * HW'(wx0) +
                              HW'(p3_reg[c*8 +: 8]) * HW'(wx1);
            end
            v_reg.out_red   <= vsum[0][2*FB +: 8];
            v_reg.out_green <= vsum[1][2*FB +: 8];
            v_reg.out_blue  <= vsum[2][2*FB +: 8];
            v_reg.out_alpha <= vsum[3][2*FB +: 8];
        end
    end

    assign out_valid = v_valid_reg;
    assign out_item  = v_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid && cmd.is_load && advance |=> !r_valid_reg)
        else $error("load produced a result");
    a_smp_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        smp && advance |=> r_valid_reg) else $error("sample lost");

endmodule

[sv/bilinear_image_scaler_unit.sv]
// Bilinear image scaler: accepts one transaction per cycle, loads and samples alike,
// unless m_ready stalls the output. A sample's result passes through the first and
// second front stages, the queue, the memory read and the horizontal and vertical
// blend registers in that order; a load gives no result.
// The four-bank pixel store reads all four neighbors at once.
// Reset (aresetn low, synchronous) clears control state and restores the register
// defaults; the pixel store is not cleared and is undefined until written.
module bilinear_image_scaler_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  bis_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bis_pkg::out_item_t  m_data
);
    logic f_valid, f_ready, q_valid, q_ready;
    bis_pkg::cmd_t f_cmd, q_cmd;

    bis_front u_front (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .in_valid(s_valid), .in_ready(s_ready), .in_item(s_data),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    bis_fifo u_fifo (
        .aclk, .aresetn,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
    );

    bis_back u_back (
        .aclk, .aresetn,
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .out_valid(m_valid), .out_ready(m_ready), .out_item(m_data)
    );

endmodule
